// ===== rtl/rbi_pkg.sv =====
// ----------------------------------------------------------------------------
// rbi_pkg
// Shared types and sizes for the rectilinear bilinear interpolation core.
// ----------------------------------------------------------------------------
`default_nettype none

package rbi_pkg;

	// value format and grid size
	localparam int VALUE_WIDTH = 32;
	localparam int MAX_X       = 64;
	localparam int MAX_Z       = 64;
	localparam int XAW         = $clog2(MAX_X);
	localparam int ZAW         = $clog2(MAX_Z);
	localparam int GAW         = XAW + ZAW;
	localparam int SAW         = (XAW > ZAW) ? XAW : ZAW;
	localparam int CNTW        = 7;

	// arithmetic widths
	localparam int DIFW   = VALUE_WIDTH + 1;
	localparam int ACCW   = 3 * VALUE_WIDTH + 6;
	localparam int NUMW   = ACCW + 1;
	localparam int DIVW   = 2 * VALUE_WIDTH + 4;
	localparam int MSTEPS = DIFW;
	localparam int STW    = $clog2(NUMW + 1);

	typedef enum logic [1:0] {
		FUNC_WR_X      = 2'd0,
		FUNC_WR_Z      = 2'd1,
		FUNC_WR_SAMPLE = 2'd2,
		FUNC_QUERY     = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STATUS_OK           = 2'd0,
		STATUS_EMPTY        = 2'd1,
		STATUS_OOB          = 2'd2,
		STATUS_ZERO_SPACING = 2'd3
	} status_t;

	localparam logic CFG_X_COUNT = 1'b0;
	localparam logic CFG_Z_COUNT = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_CORNER,
		S_CHECK,
		S_SAMPLE,
		S_MUL_SET,
		S_MUL_RUN,
		S_MUL_END,
		S_DIV_SET,
		S_DIV_RUN,
		S_FINISH
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/rbi_ram.sv =====
// ----------------------------------------------------------------------------
// rbi_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rbi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read first port, registered read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

// ===== rtl/rectilinear_bilinear_interp_core.sv =====
// ----------------------------------------------------------------------------
// rectilinear_bilinear_interp_core
// Bilinear interpolation of a sample grid over two ascending coordinate lists.
//
// A command is taken when start is high and busy is low. func selects a write
// of an x coordinate, a z coordinate or a grid sample (written when taken, no
// result), or a query of point (query_x, query_z). A query returns one word on
// interp_value/status, marked by done for exactly one cycle; the receiver
// cannot stall it. The user sets x_count and z_count through cfg_we/
// cfg_index/cfg_wdata while the core is idle; the core does not check this.
// A query scans both coordinate lists in parallel, one entry per cycle from
// single-port RAMs, reads the two corner coordinates per axis and the four
// corner samples, then forms the numerator and denominator on a bit-serial
// shift-add multiplier (nine passes) and divides on a bit-serial restoring
// divider. An empty grid is answered without a scan.
// The next command is taken in the cycle that done is shown.
// Reset clears the counts and the control state; the coordinate and sample
// RAMs are not cleared and must be written before use.
// ----------------------------------------------------------------------------
`default_nettype none

module rectilinear_bilinear_interp_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [1:0]                       func,
	input  wire logic [5:0]                       row_index,
	input  wire logic [5:0]                       col_index,
	input  wire logic [rbi_pkg::VALUE_WIDTH-1:0]  write_value,
	input  wire logic [rbi_pkg::VALUE_WIDTH-1:0]  query_x,
	input  wire logic [rbi_pkg::VALUE_WIDTH-1:0]  query_z,
	input  wire logic                             cfg_we,
	input  wire logic                             cfg_index,
	input  wire logic [rbi_pkg::CNTW-1:0]         cfg_wdata,
	output logic                                  done,
	output logic      [rbi_pkg::VALUE_WIDTH-1:0]  interp_value,
	output logic      [1:0]                       status
);

	import rbi_pkg::*;

	localparam int W = VALUE_WIDTH;

	state_t state_q, state_d;

	// configuration
	logic [CNTW-1:0] x_count_q, z_count_q;

	// query context
	logic [CNTW-1:0]  nx_q, nz_q, nmax;
	logic [W-1:0]     qx_q, qz_q;
	logic [SAW:0]     k_q;
	logic             vld_s1;
	logic [SAW-1:0]   idx_s1;
	logic             fx_q, fz_q;
	logic [XAW-1:0]   ix_q, i1_q, i2_q, i1_c, i2_c;
	logic [ZAW-1:0]   iz_q, j1_q, j2_q, j1_c, j2_c;
	logic [2:0]       sub_q;
	logic [W-1:0]     x1_q, x2_q, z1_q, z2_q;
	logic [W-1:0]     samp_q [4];
	status_t          stat_q;

	// multiplier and divider
	logic [2:0]       term_q;
	logic             phase_q;
	logic [STW-1:0]   step_q;
	logic [ACCW-1:0]  acc_q, mcand_q, num_q;
	logic [DIFW-1:0]  mplier_q;
	logic [NUMW-1:0]  n_q;
	logic [DIVW-1:0]  d_q, rem_q;
	logic             neg_q;

	// memory ports
	logic           x_we, z_we, g_we;
	logic [XAW-1:0] x_addr;
	logic [ZAW-1:0] z_addr;
	logic [GAW-1:0] g_addr;
	logic [W-1:0]   x_rd, z_rd, g_rd;

	logic accept;
	assign accept = start && !busy;

	rbi_ram #(.WIDTH(W), .DEPTH(MAX_X)) u_x_ram (
		.clk(clk), .we(x_we), .addr(x_addr), .wdata(write_value), .rdata(x_rd)
	);

	rbi_ram #(.WIDTH(W), .DEPTH(MAX_Z)) u_z_ram (
		.clk(clk), .we(z_we), .addr(z_addr), .wdata(write_value), .rdata(z_rd)
	);

	rbi_ram #(.WIDTH(W), .DEPTH(MAX_X * MAX_Z)) u_grid_ram (
		.clk(clk), .we(g_we), .addr(g_addr), .wdata(write_value), .rdata(g_rd)
	);

	// scan length and corner indexes
	always_comb begin
		nmax = (nx_q > nz_q) ? nx_q : nz_q;
		i1_c = (ix_q == '0) ? '0 : ix_q - 1'b1;
		j1_c = (iz_q == '0) ? '0 : iz_q - 1'b1;
		i2_c = ((CNTW'(i1_c) + 1'b1) < nx_q) ? i1_c + 1'b1 : XAW'(nx_q - 1'b1);
		j2_c = ((CNTW'(j1_c) + 1'b1) < nz_q) ? j1_c + 1'b1 : ZAW'(nz_q - 1'b1);
	end

	// clamped counts at query start
	logic [CNTW-1:0] nx_c, nz_c;
	assign nx_c = (x_count_q > CNTW'(MAX_X)) ? CNTW'(MAX_X) : x_count_q;
	assign nz_c = (z_count_q > CNTW'(MAX_Z)) ? CNTW'(MAX_Z) : z_count_q;

	// scan compare on returned coordinates
	logic x_hit, z_hit;
	assign x_hit = vld_s1 && !fx_q && (CNTW'(idx_s1) < nx_q) &&
		($signed(x_rd) >= $signed(qx_q));
	assign z_hit = vld_s1 && !fz_q && (CNTW'(idx_s1) < nz_q) &&
		($signed(z_rd) >= $signed(qz_q));

	// cell weights
	logic [DIFW-1:0] ax, bx, az, bz, dx, dz, op_a, op_b;
	always_comb begin
		ax = {x2_q[W-1], x2_q} - {qx_q[W-1], qx_q};
		bx = {qx_q[W-1], qx_q} - {x1_q[W-1], x1_q};
		az = {z2_q[W-1], z2_q} - {qz_q[W-1], qz_q};
		bz = {qz_q[W-1], qz_q} - {z1_q[W-1], z1_q};
		dx = {x2_q[W-1], x2_q} - {x1_q[W-1], x1_q};
		dz = {z2_q[W-1], z2_q} - {z1_q[W-1], z1_q};
		if (term_q == 3'd4) begin
			op_a = dx;
			op_b = dz;
		end else begin
			op_a = term_q[0] ? bx : ax;
			op_b = term_q[1] ? bz : az;
		end
	end

	// divider operands and step
	logic [ACCW-1:0] nm, dm;
	logic [DIVW:0]   trial, trial_sub;
	logic            trial_ge;
	always_comb begin
		nm        = num_q[ACCW-1] ? (~num_q + 1'b1) : num_q;
		dm        = acc_q[ACCW-1] ? (~acc_q + 1'b1) : acc_q;
		trial     = {rem_q, n_q[NUMW-1]};
		trial_ge  = trial >= {1'b0, d_q};
		trial_sub = trial - {1'b0, d_q};
	end

	// rounding result saturated to the value range
	logic [W-1:0] sat_val;
	logic         q_ovf, q_neg;
	always_comb begin
		q_ovf = |n_q[NUMW-1:W-1];
		q_neg = neg_q && (n_q != '0);
		if (q_neg) begin
			sat_val = q_ovf ? {1'b1, {(W-1){1'b0}}} : (~n_q[W-1:0] + 1'b1);
		end else begin
			sat_val = q_ovf ? {1'b0, {(W-1){1'b1}}} : n_q[W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && func_t'(func) == FUNC_QUERY) begin
					state_d = (nx_c == '0 || nz_c == '0) ? S_FINISH : S_SCAN;
				end
			end
			S_SCAN: begin
				if (!(k_q < (SAW+1)'(nmax)) && !vld_s1) begin
					state_d = (fx_q && fz_q) ? S_CORNER : S_FINISH;
				end
			end
			S_CORNER:  if (sub_q == 3'd2) state_d = S_CHECK;
			S_CHECK: begin
				state_d = (x1_q == x2_q || z1_q == z2_q) ? S_FINISH : S_SAMPLE;
			end
			S_SAMPLE:  if (sub_q == 3'd4) state_d = S_MUL_SET;
			S_MUL_SET: state_d = S_MUL_RUN;
			S_MUL_RUN: if (step_q == STW'(MSTEPS - 1)) state_d = S_MUL_END;
			S_MUL_END: state_d = (!phase_q && term_q == 3'd4) ? S_DIV_SET : S_MUL_SET;
			S_DIV_SET: state_d = S_DIV_RUN;
			S_DIV_RUN: if (step_q == STW'(NUMW - 1)) state_d = S_FINISH;
			S_FINISH:  state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// memory control and handshake
	always_comb begin
		busy   = (state_q != S_IDLE);
		x_we   = 1'b0;
		z_we   = 1'b0;
		g_we   = 1'b0;
		x_addr = row_index[XAW-1:0];
		z_addr = col_index[ZAW-1:0];
		g_addr = {row_index[XAW-1:0], col_index[ZAW-1:0]};
		unique case (state_q)
			S_IDLE: begin
				x_we = accept && func_t'(func) == FUNC_WR_X;
				z_we = accept && func_t'(func) == FUNC_WR_Z;
				g_we = accept && func_t'(func) == FUNC_WR_SAMPLE;
			end
			S_SCAN: begin
				x_addr = k_q[XAW-1:0];
				z_addr = k_q[ZAW-1:0];
			end
			S_CORNER: begin
				x_addr = (sub_q == 3'd0) ? i1_q : i2_q;
				z_addr = (sub_q == 3'd0) ? j1_q : j2_q;
			end
			S_SAMPLE: begin
				g_addr = {(sub_q[0] ? i2_q : i1_q), (sub_q[1] ? j2_q : j1_q)};
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			x_count_q <= '0;
			z_count_q <= '0;
			done      <= 1'b0;
			vld_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= (state_q == S_FINISH);
			if (cfg_we) begin
				if (cfg_index == CFG_X_COUNT) x_count_q <= cfg_wdata;
				if (cfg_index == CFG_Z_COUNT) z_count_q <= cfg_wdata;
			end
			vld_s1 <= (state_q == S_SCAN) && (k_q < (SAW+1)'(nmax));
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				qx_q   <= query_x;
				qz_q   <= query_z;
				nx_q   <= nx_c;
				nz_q   <= nz_c;
				k_q    <= '0;
				fx_q   <= 1'b0;
				fz_q   <= 1'b0;
				stat_q <= STATUS_EMPTY;
			end
			S_SCAN: begin
				// issue one entry per cycle, compare the previous one
				idx_s1 <= k_q[SAW-1:0];
				if (k_q < (SAW+1)'(nmax)) k_q <= k_q + 1'b1;
				if (x_hit) begin
					fx_q <= 1'b1;
					ix_q <= idx_s1[XAW-1:0];
				end
				if (z_hit) begin
					fz_q <= 1'b1;
					iz_q <= idx_s1[ZAW-1:0];
				end
				stat_q <= STATUS_OOB;
				i1_q   <= i1_c;
				i2_q   <= i2_c;
				j1_q   <= j1_c;
				j2_q   <= j2_c;
				sub_q  <= '0;
			end
			S_CORNER: begin
				sub_q <= sub_q + 1'b1;
				if (sub_q == 3'd1) begin
					x1_q <= x_rd;
					z1_q <= z_rd;
				end
				if (sub_q == 3'd2) begin
					x2_q <= x_rd;
					z2_q <= z_rd;
				end
			end
			S_CHECK: begin
				stat_q <= STATUS_ZERO_SPACING;
				sub_q  <= '0;
			end
			S_SAMPLE: begin
				sub_q <= sub_q + 1'b1;
				if (sub_q != 3'd0) samp_q[2'(sub_q - 1'b1)] <= g_rd;
				term_q  <= '0;
				phase_q <= 1'b0;
				num_q   <= '0;
			end
			S_MUL_SET: begin
				step_q <= '0;
				if (!phase_q) begin
					acc_q    <= '0;
					mcand_q  <= {{(ACCW-DIFW){op_a[DIFW-1]}}, op_a};
					mplier_q <= op_b;
				end else begin
					acc_q    <= num_q;
					mcand_q  <= acc_q;
					mplier_q <= {samp_q[term_q[1:0]][W-1], samp_q[term_q[1:0]]};
				end
			end
			S_MUL_RUN: begin
				// the top multiplier bit carries negative weight
				if (mplier_q[0]) begin
					acc_q <= (step_q == STW'(MSTEPS - 1)) ? acc_q - mcand_q : acc_q + mcand_q;
				end
				mcand_q  <= {mcand_q[ACCW-2:0], 1'b0};
				mplier_q <= {mplier_q[DIFW-1], mplier_q[DIFW-1:1]};
				step_q   <= step_q + 1'b1;
			end
			S_MUL_END: begin
				if (!phase_q) begin
					if (term_q != 3'd4) phase_q <= 1'b1;
				end else begin
					num_q   <= acc_q;
					phase_q <= 1'b0;
					term_q  <= term_q + 1'b1;
				end
			end
			S_DIV_SET: begin
				// round to nearest: (2|num| + |den|) / (2|den|)
				neg_q  <= num_q[ACCW-1] ^ acc_q[ACCW-1];
				n_q    <= {nm, 1'b0} + {1'b0, dm};
				d_q    <= {dm[DIVW-2:0], 1'b0};
				rem_q  <= '0;
				step_q <= '0;
			end
			S_DIV_RUN: begin
				rem_q  <= trial_ge ? trial_sub[DIVW-1:0] : trial[DIVW-1:0];
				n_q    <= {n_q[NUMW-2:0], trial_ge};
				step_q <= step_q + 1'b1;
				stat_q <= STATUS_OK;
			end
			S_FINISH: begin
				status       <= stat_q;
				interp_value <= (stat_q == STATUS_OK) ? sat_val : '0;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
